FILE: hdl/lnb_pkg.sv
package lnb_pkg;

   localparam int MAX_COLS  = 64;
   localparam int COL_W     = $clog2(MAX_COLS);
   localparam int LEN_W     = 7;
   localparam int DATA_W    = 16;
   localparam int BUF_W     = 32;
   localparam int ACC_W     = 48;
   localparam int OUT_W     = 32;
   localparam int DIV_STEPS = ACC_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [DATA_W-1:0] ONE_Q412 = 16'h1000;

   localparam logic CSR_ROW_LENGTH = 1'b0;
   localparam logic CSR_USE_SCALE  = 1'b1;

   typedef struct packed {
      logic             load;
      logic             l1;
      logic             l2;
      logic             l3;
      logic             e1;
      logic             e2;
      logic             e3;
      logic             e4;
      logic             e5;
      logic             e6;
      logic             div_step;
      logic             qf;
      logic             p1;
      logic             p2;
      logic             p3;
      logic             clr_sums;
      logic             use_scale;
      logic             last;
      logic [COL_W-1:0] addr;
      logic [LEN_W-1:0] len;
   } lnb_cmd_type;

   function automatic logic [ACC_W-1:0] sat48(input logic [ACC_W:0] v);
      logic [ACC_W-1:0] r;
      if (v[ACC_W] != v[ACC_W-1]) begin
         r = v[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r = v[ACC_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] sat32(input logic [ACC_W-1:0] v);
      logic [OUT_W-1:0] r;
      if ((&v[ACC_W-1:OUT_W-1]) || !(|v[ACC_W-1:OUT_W-1])) begin
         r = v[OUT_W-1:0];
      end else begin
         r = v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

FILE: hdl/lnb_req_if.sv
interface lnb_req_if;
   logic                         valid;
   logic                         ready;
   logic [lnb_pkg::DATA_W-1:0]   grad_out;
   logic [lnb_pkg::DATA_W-1:0]   x_value;
   logic [lnb_pkg::DATA_W-1:0]   scale_value;
   logic [lnb_pkg::DATA_W-1:0]   row_mean;
   logic [lnb_pkg::DATA_W-1:0]   row_rstd;
   logic                         final_row;

   modport source (output valid, grad_out, x_value, scale_value, row_mean, row_rstd,
                   final_row, input ready);
   modport sink (input valid, grad_out, x_value, scale_value, row_mean, row_rstd,
                 final_row, output ready);
endinterface

FILE: hdl/lnb_rsp_if.sv
interface lnb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lnb_pkg::COL_W-1:0]   column;
   logic [lnb_pkg::OUT_W-1:0]   grad_in;
   logic [lnb_pkg::OUT_W-1:0]   grad_scale;
   logic [lnb_pkg::OUT_W-1:0]   grad_shift;
   logic                        param_valid;
   logic                        last;

   modport source (output valid, column, grad_in, grad_scale, grad_shift, param_valid,
                   last, input ready);
   modport sink (input valid, column, grad_in, grad_scale, grad_shift, param_valid,
                 last, output ready);
endinterface

FILE: hdl/lnb_ctrl.sv
module lnb_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [lnb_pkg::LEN_W-1:0]    csr_wdata,
   output lnb_pkg::lnb_cmd_type         cmd
);

   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_L1   = 5'd1;
   localparam logic [4:0] ST_L2   = 5'd2;
   localparam logic [4:0] ST_L3   = 5'd3;
   localparam logic [4:0] ST_E0   = 5'd4;
   localparam logic [4:0] ST_E1   = 5'd5;
   localparam logic [4:0] ST_E2   = 5'd6;
   localparam logic [4:0] ST_E3   = 5'd7;
   localparam logic [4:0] ST_E4   = 5'd8;
   localparam logic [4:0] ST_E5   = 5'd9;
   localparam logic [4:0] ST_E6   = 5'd10;
   localparam logic [4:0] ST_DIV  = 5'd11;
   localparam logic [4:0] ST_QF   = 5'd12;
   localparam logic [4:0] ST_P1   = 5'd13;
   localparam logic [4:0] ST_P2   = 5'd14;
   localparam logic [4:0] ST_P3   = 5'd15;
   localparam logic [4:0] ST_OUT  = 5'd16;

   logic [4:0]                      state_ff, state_in;
   logic [lnb_pkg::LEN_W-1:0]       col_ff, col_in;
   logic [lnb_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [lnb_pkg::LEN_W-1:0]       row_length_ff, row_length_in;
   logic                            use_scale_ff, use_scale_in;
   logic [lnb_pkg::LEN_W-1:0]       len_w;
   logic                            row_full_w;

   always_comb begin
      if (row_length_ff == '0) begin
         len_w = lnb_pkg::LEN_W'(1);
      end else if (row_length_ff > lnb_pkg::LEN_W'(lnb_pkg::MAX_COLS)) begin
         len_w = lnb_pkg::LEN_W'(lnb_pkg::MAX_COLS);
      end else begin
         len_w = row_length_ff;
      end
   end

   assign row_full_w = ({1'b0, col_ff} + 1'b1) >= {1'b0, len_w};
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);

   always_comb begin
      cmd           = '0;
      cmd.addr      = col_ff[lnb_pkg::COL_W-1:0];
      cmd.len       = len_w;
      cmd.use_scale = use_scale_ff;
      cmd.last      = (col_ff == len_w - 1'b1);
      state_in      = state_ff;
      col_in        = col_ff;
      div_cnt_in    = div_cnt_ff;
      row_length_in = row_length_ff;
      use_scale_in  = use_scale_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_L1;
            end
         end
         ST_L1: begin
            cmd.l1   = 1'b1;
            state_in = ST_L2;
         end
         ST_L2: begin
            cmd.l2   = 1'b1;
            state_in = ST_L3;
         end
         ST_L3: begin
            cmd.l3 = 1'b1;
            if (row_full_w) begin
               col_in   = '0;
               state_in = ST_E0;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_E0: state_in = ST_E1;
         ST_E1: begin
            cmd.e1   = 1'b1;
            state_in = ST_E2;
         end
         ST_E2: begin
            cmd.e2   = 1'b1;
            state_in = ST_E3;
         end
         ST_E3: begin
            cmd.e3   = 1'b1;
            state_in = ST_E4;
         end
         ST_E4: begin
            cmd.e4   = 1'b1;
            state_in = ST_E5;
         end
         ST_E5: begin
            cmd.e5   = 1'b1;
            state_in = ST_E6;
         end
         ST_E6: begin
            cmd.e6     = 1'b1;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == lnb_pkg::DIV_CNT_W'(lnb_pkg::DIV_STEPS - 1)) begin
               state_in = ST_QF;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_QF: begin
            cmd.qf   = 1'b1;
            state_in = ST_P1;
         end
         ST_P1: begin
            cmd.p1   = 1'b1;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd.p2   = 1'b1;
            state_in = ST_P3;
         end
         ST_P3: begin
            cmd.p3   = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (cmd.last) begin
                  cmd.clr_sums = 1'b1;
                  col_in       = '0;
                  state_in     = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  state_in = ST_E0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         if (csr_index == lnb_pkg::CSR_ROW_LENGTH) begin
            row_length_in = csr_wdata;
            col_in        = '0;
            cmd.clr_sums  = 1'b1;
         end else begin
            use_scale_in = csr_wdata[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         div_cnt_ff    <= '0;
         row_length_ff <= lnb_pkg::LEN_W'(lnb_pkg::MAX_COLS);
         use_scale_ff  <= 1'b1;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         div_cnt_ff    <= div_cnt_in;
         row_length_ff <= row_length_in;
         use_scale_ff  <= use_scale_in;
      end
   end

endmodule

FILE: hdl/lnb_datapath.sv
module lnb_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lnb_pkg::lnb_cmd_type         cmd,
   input  logic [lnb_pkg::DATA_W-1:0]   grad_out,
   input  logic [lnb_pkg::DATA_W-1:0]   x_value,
   input  logic [lnb_pkg::DATA_W-1:0]   scale_value,
   input  logic [lnb_pkg::DATA_W-1:0]   row_mean,
   input  logic [lnb_pkg::DATA_W-1:0]   row_rstd,
   input  logic                         final_row,
   output logic [lnb_pkg::COL_W-1:0]    column,
   output logic [lnb_pkg::OUT_W-1:0]    grad_in,
   output logic [lnb_pkg::OUT_W-1:0]    grad_scale,
   output logic [lnb_pkg::OUT_W-1:0]    grad_shift,
   output logic                         param_valid,
   output logic                         last
);

   localparam int AW = lnb_pkg::ACC_W;
   localparam int BW = lnb_pkg::BUF_W;
   localparam int OW = lnb_pkg::OUT_W;
   localparam int LW = lnb_pkg::LEN_W;

   // per-column stores
   logic [BW-1:0] norm_mem [lnb_pkg::MAX_COLS];
   logic [BW-1:0] sg_mem   [lnb_pkg::MAX_COLS];
   logic [AW-1:0] wacc_mem [lnb_pkg::MAX_COLS];
   logic [AW-1:0] bacc_mem [lnb_pkg::MAX_COLS];
   logic [lnb_pkg::MAX_COLS-1:0] wv_ff;

   logic [BW-1:0] norm_rd_ff, sg_rd_ff;
   logic [AW-1:0] wacc_rd_ff, bacc_rd_ff;
   logic          wv_rd_ff;

   // element capture
   logic [15:0] gy_ff, g_ff, rs_ff;
   logic [16:0] d_ff;
   logic        fin_ff;
   logic [BW-1:0] norm_ff, scaled_ff;
   logic [AW-1:0] wterm_ff, snterm_ff;
   logic [AW-1:0] ss_ff, ssn_ff;

   // emit path
   logic [55:0] plo_ff, phi_ff;
   logic        tsign_ff;
   logic [79:0] tacc_ff;
   logic [AW-1:0] t_ff, s_ff;
   logic [AW-1:0] n_ff;
   logic [LW-1:0] rem_ff;
   logic        qsign_ff;
   logic [39:0] dmag_ff;
   logic        dsign_ff;
   logic [35:0] pm0_ff, pm1_ff;

   logic [OW-1:0] col_unused_w;
   logic [lnb_pkg::COL_W-1:0] column_ff;
   logic [OW-1:0] grad_in_ff, grad_scale_ff, grad_shift_ff;
   logic          param_valid_ff, last_ff;

   // combinational helpers
   logic [16:0] dmag_w;
   logic [15:0] gymag_w, gmag_w;
   logic [32:0] np_w;
   logic [28:0] nm_w;
   logic [31:0] sp_w;
   logic [22:0] sm_w;
   logic [31:0] normmag_w, scmag_w;
   logic [47:0] wp_w, wm_w;
   logic [55:0] snp_w;
   logic [AW-1:0] snm_w;
   logic [AW-1:0] weff_w, beff_w, gy16_w;
   logic [31:0] nrdmag_w;
   logic [AW-1:0] ssnmag_w;
   logic [63:0] tm_w;
   logic [AW-1:0] smag_w;
   logic [7:0]  r2_w;
   logic        ge_w;
   logic [AW:0] q_w;
   logic [49:0] diff_w, dmagf_w;
   logic [56:0] full_w;
   logic [48:0] gm_w;
   logic [OW-1:0] gi_w;

   assign dmag_w   = d_ff[16] ? (~d_ff + 17'd1) : d_ff;
   assign gymag_w  = gy_ff[15] ? (~gy_ff + 16'd1) : gy_ff;
   assign gmag_w   = g_ff[15] ? (~g_ff + 16'd1) : g_ff;
   assign np_w     = dmag_w * rs_ff;
   assign nm_w     = 29'((np_w + 33'd8) >> 4);
   assign sp_w     = gymag_w * gmag_w;
   assign sm_w     = 23'((33'(sp_w) + 33'd128) >> 8);

   assign normmag_w = norm_ff[BW-1] ? (~norm_ff + 1'b1) : norm_ff;
   assign scmag_w   = scaled_ff[BW-1] ? (~scaled_ff + 1'b1) : scaled_ff;
   assign wp_w      = gymag_w * normmag_w;
   assign wm_w      = (wp_w + 48'd2048) >> 12;
   assign snp_w     = scmag_w[23:0] * normmag_w;
   assign snm_w     = AW'((snp_w + 56'd32768) >> 16);

   assign weff_w = wv_rd_ff ? wacc_rd_ff : '0;
   assign beff_w = wv_rd_ff ? bacc_rd_ff : '0;
   assign gy16_w = {{(AW-20){gy_ff[15]}}, gy_ff, 4'b0000};

   assign nrdmag_w = norm_rd_ff[BW-1] ? (~norm_rd_ff + 1'b1) : norm_rd_ff;
   assign ssnmag_w = ssn_ff[AW-1] ? (~ssn_ff + 1'b1) : ssn_ff;
   assign tm_w     = tacc_ff[79:16];
   assign smag_w   = s_ff[AW-1] ? (~s_ff + 1'b1) : s_ff;

   assign r2_w = {rem_ff, n_ff[AW-1]};
   assign ge_w = r2_w >= {1'b0, cmd.len};

   assign q_w     = qsign_ff ? (~{1'b0, n_ff} + 1'b1) : {1'b0, n_ff};
   assign diff_w  = {{18{sg_rd_ff[BW-1]}}, sg_rd_ff} - {q_w[AW], q_w};
   assign dmagf_w = diff_w[49] ? (~diff_w + 1'b1) : diff_w;

   assign full_w = {1'b0, pm1_ff, 20'b0} + 57'(pm0_ff) + 57'd128;
   assign gm_w   = full_w[56:8];

   always_comb begin
      if (|gm_w[48:OW-1]) begin
         gi_w = dsign_ff ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
      end else begin
         gi_w = dsign_ff ? (~gm_w[OW-1:0] + 1'b1) : gm_w[OW-1:0];
      end
   end

   assign col_unused_w = '0;

   // memories: one write port, registered read at cmd.addr
   always_ff @(posedge clock) begin
      norm_rd_ff <= norm_mem[cmd.addr];
      sg_rd_ff   <= sg_mem[cmd.addr];
      wacc_rd_ff <= wacc_mem[cmd.addr];
      bacc_rd_ff <= bacc_mem[cmd.addr];
      if (cmd.l2) begin
         norm_mem[cmd.addr] <= norm_ff;
         sg_mem[cmd.addr]   <= scaled_ff;
      end
      if (cmd.l3) begin
         wacc_mem[cmd.addr] <= lnb_pkg::sat48({weff_w[AW-1], weff_w} +
                                              {wterm_ff[AW-1], wterm_ff});
         bacc_mem[cmd.addr] <= lnb_pkg::sat48({beff_w[AW-1], beff_w} +
                                              {gy16_w[AW-1], gy16_w});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff    <= '0;
         wv_rd_ff <= 1'b0;
         ss_ff    <= '0;
         ssn_ff   <= '0;
      end else begin
         wv_rd_ff <= wv_ff[cmd.addr];
         if (cmd.l3) begin
            wv_ff[cmd.addr] <= 1'b1;
         end else if (cmd.p3 && fin_ff) begin
            wv_ff[cmd.addr] <= 1'b0;
         end
         if (cmd.clr_sums) begin
            ss_ff  <= '0;
            ssn_ff <= '0;
         end else if (cmd.l3) begin
            ss_ff  <= lnb_pkg::sat48({ss_ff[AW-1], ss_ff} +
                                     {{(AW-BW+1){scaled_ff[BW-1]}}, scaled_ff});
            ssn_ff <= lnb_pkg::sat48({ssn_ff[AW-1], ssn_ff} +
                                     {snterm_ff[AW-1], snterm_ff});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gy_ff  <= grad_out;
         g_ff   <= cmd.use_scale ? scale_value : lnb_pkg::ONE_Q412;
         d_ff   <= {x_value[15], x_value} - {row_mean[15], row_mean};
         rs_ff  <= row_rstd;
         fin_ff <= final_row;
      end
      if (cmd.l1) begin
         norm_ff   <= d_ff[16] ? (~{3'b000, nm_w} + 1'b1) : {3'b000, nm_w};
         scaled_ff <= (gy_ff[15] ^ g_ff[15]) ? (~{9'd0, sm_w} + 1'b1) : {9'd0, sm_w};
      end
      if (cmd.l2) begin
         wterm_ff  <= (gy_ff[15] ^ norm_ff[BW-1]) ? (~wm_w + 1'b1) : wm_w;
         snterm_ff <= (scaled_ff[BW-1] ^ norm_ff[BW-1]) ? (~snm_w + 1'b1) : snm_w;
      end
      if (cmd.e1) begin
         plo_ff   <= nrdmag_w * ssnmag_w[23:0];
         tsign_ff <= norm_rd_ff[BW-1] ^ ssn_ff[AW-1];
      end
      if (cmd.e2) begin
         phi_ff <= nrdmag_w * ssnmag_w[47:24];
      end
      if (cmd.e3) begin
         tacc_ff <= {phi_ff, 24'b0} + 80'(plo_ff) + 80'd32768;
      end
      if (cmd.e4) begin
         if (|tm_w[63:AW-1]) begin
            t_ff <= tsign_ff ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         end else begin
            t_ff <= tsign_ff ? (~tm_w[AW-1:0] + 1'b1) : tm_w[AW-1:0];
         end
      end
      if (cmd.e5) begin
         s_ff <= lnb_pkg::sat48({ss_ff[AW-1], ss_ff} + {t_ff[AW-1], t_ff});
      end
      if (cmd.e6) begin
         n_ff     <= smag_w + AW'(cmd.len >> 1);
         qsign_ff <= s_ff[AW-1];
         rem_ff   <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= ge_w ? LW'(r2_w - {1'b0, cmd.len}) : r2_w[LW-1:0];
         n_ff   <= {n_ff[AW-2:0], ge_w};
      end
      if (cmd.qf) begin
         dmag_ff  <= (|dmagf_w[49:39]) ? 40'h80_0000_0000 : dmagf_w[39:0];
         dsign_ff <= diff_w[49];
      end
      if (cmd.p1) begin
         pm0_ff <= rs_ff * dmag_ff[19:0];
      end
      if (cmd.p2) begin
         pm1_ff <= rs_ff * dmag_ff[39:20];
      end
      if (cmd.p3) begin
         column_ff      <= cmd.addr;
         grad_in_ff     <= gi_w;
         grad_scale_ff  <= fin_ff ? lnb_pkg::sat32(weff_w) : col_unused_w;
         grad_shift_ff  <= fin_ff ? lnb_pkg::sat32(beff_w) : col_unused_w;
         param_valid_ff <= fin_ff;
         last_ff        <= cmd.last;
      end
   end

   assign column      = column_ff;
   assign grad_in     = grad_in_ff;
   assign grad_scale  = grad_scale_ff;
   assign grad_shift  = grad_shift_ff;
   assign param_valid = param_valid_ff;
   assign last        = last_ff;

endmodule

FILE: hdl/layer_norm_backward_row_unit.sv
// Each element beat passes through capture, two multiply stages and accumulate.
// After the row's last element, each column result goes through products, the
// 48-step bit-serial divider for the row-length division, output scaling and
// the output handshake. A row of L columns emits L result beats, one at a time.
// Reset is synchronous, active high: row length 64, scale use on, row sums,
// column count and parameter gradient accumulators cleared.
module layer_norm_backward_row_unit (
   input  logic                        clock,
   input  logic                        reset,
   lnb_req_if.sink                     req,
   lnb_rsp_if.source                   rsp,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [lnb_pkg::LEN_W-1:0]   csr_wdata
);

   lnb_pkg::lnb_cmd_type cmd;

   lnb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   lnb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .grad_out    (req.grad_out),
      .x_value     (req.x_value),
      .scale_value (req.scale_value),
      .row_mean    (req.row_mean),
      .row_rstd    (req.row_rstd),
      .final_row   (req.final_row),
      .column      (rsp.column),
      .grad_in     (rsp.grad_in),
      .grad_scale  (rsp.grad_scale),
      .grad_shift  (rsp.grad_shift),
      .param_valid (rsp.param_valid),
      .last        (rsp.last)
   );

   a_no_accept_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready)
      else $error("input taken while result beat pending");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.last) |=> !rsp.valid)
      else $error("result beat after last column");

   a_param_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.param_valid) |-> (rsp.grad_scale == '0 && rsp.grad_shift == '0))
      else $error("parameter gradients nonzero on non-final row");

endmodule

FILE: verif/layer_norm_backward_row_unit_tb.sv
module layer_norm_backward_row_unit_tb;

   localparam int CLK_HALF    = 6;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int ITEM_TARGET = 500;
   localparam int SETTLE      = 100;

   typedef struct packed {
      logic [lnb_pkg::COL_W-1:0] column;
      logic [lnb_pkg::OUT_W-1:0] grad_in;
      logic [lnb_pkg::OUT_W-1:0] grad_scale;
      logic [lnb_pkg::OUT_W-1:0] grad_shift;
      logic                      param_valid;
      logic                      last;
   } col_result_type;

   class lnb_scoreboard;
      longint         norm_mem[lnb_pkg::MAX_COLS];
      longint         sgrad_mem[lnb_pkg::MAX_COLS];
      longint         wgrad_acc[lnb_pkg::MAX_COLS];
      longint         bgrad_acc[lnb_pkg::MAX_COLS];
      longint         row_sum_sg;
      longint         row_sum_sgn;
      int             col_cnt;
      int             row_len_reg;
      bit             scale_on;
      col_result_type expected_cols[$];
      int             mismatches;
      int             beats_in;
      int             beats_out;
      int             rows_done;

      function new();
         for (int i = 0; i < lnb_pkg::MAX_COLS; i++) begin
            wgrad_acc[i] = 0;
            bgrad_acc[i] = 0;
         end
         row_sum_sg  = 0;
         row_sum_sgn = 0;
         col_cnt     = 0;
         row_len_reg = 64;
         scale_on    = 1;
      endfunction

      function int pending();
         return expected_cols.size();
      endfunction

      function int eff_len();
         if (row_len_reg < 1) return 1;
         if (row_len_reg > lnb_pkg::MAX_COLS) return lnb_pkg::MAX_COLS;
         return row_len_reg;
      endfunction

      function logic [127:0] magn(longint a);
         logic [63:0] m;
         m = (a < 0) ? -a : a;
         return {64'd0, m};
      endfunction

      function longint clamp(longint v, int bits);
         longint hi;
         hi = (longint'(1) << (bits - 1)) - 1;
         if (v > hi) return hi;
         if (v < -hi - 1) return -hi - 1;
         return v;
      endfunction

      // product >> sh, round half away from zero, saturated to bits
      function longint mul_round(longint a, longint b, int sh, int bits);
         logic [127:0] p;
         logic [127:0] lim;
         bit neg;
         neg = (a < 0) != (b < 0);
         p = magn(a) * magn(b);
         if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
         lim = 128'd1 << (bits - 1);
         if (neg) begin
            if (p > lim) p = lim;
            return -longint'(p[63:0]);
         end
         if (p > lim - 1) p = lim - 1;
         return longint'(p[63:0]);
      endfunction

      function longint div_round(longint s, int len);
         longint m;
         m = ((s < 0 ? -s : s) + len / 2) / len;
         return (s < 0) ? -m : m;
      endfunction

      function void write_reg(logic idx, int value);
         if (idx == lnb_pkg::CSR_ROW_LENGTH) begin
            row_len_reg = value & 8'h7f;
            col_cnt     = 0;
            row_sum_sg  = 0;
            row_sum_sgn = 0;
         end else begin
            scale_on = value[0];
         end
      endfunction

      function void note_input(logic signed [15:0] gy, logic signed [15:0] xv,
                               logic signed [15:0] gam, logic signed [15:0] mu,
                               logic [15:0] rs, logic fin_row);
         longint g, nrm, sg, t, q, gi;
         int len, c;
         col_result_type r;
         len = eff_len();
         c   = col_cnt;
         g   = scale_on ? longint'(gam) : longint'(signed'({1'b0, lnb_pkg::ONE_Q412}));
         nrm = mul_round(longint'(xv) - longint'(mu), longint'(rs), 4, 32);
         sg  = mul_round(longint'(gy), g, 8, 32);
         norm_mem[c]  = nrm;
         sgrad_mem[c] = sg;
         wgrad_acc[c] = clamp(wgrad_acc[c] + mul_round(longint'(gy), nrm, 12, 48), 48);
         bgrad_acc[c] = clamp(bgrad_acc[c] + longint'(gy) * 16, 48);
         row_sum_sg   = clamp(row_sum_sg + sg, 48);
         row_sum_sgn  = clamp(row_sum_sgn + mul_round(sg, nrm, 16, 48), 48);
         col_cnt      = c + 1;
         beats_in++;
         if (col_cnt < len) return;
         for (int j = 0; j < len; j++) begin
            t  = mul_round(norm_mem[j], row_sum_sgn, 16, 48);
            q  = div_round(clamp(row_sum_sg + t, 48), len);
            gi = mul_round(longint'(rs), sgrad_mem[j] - q, 8, 32);
            r.column  = lnb_pkg::COL_W'(j);
            r.grad_in = 32'(gi);
            if (fin_row) begin
               r.grad_scale  = 32'(clamp(wgrad_acc[j], 32));
               r.grad_shift  = 32'(clamp(bgrad_acc[j], 32));
               r.param_valid = 1'b1;
               wgrad_acc[j]  = 0;
               bgrad_acc[j]  = 0;
            end else begin
               r.grad_scale  = '0;
               r.grad_shift  = '0;
               r.param_valid = 1'b0;
            end
            r.last = (j + 1 == len);
            expected_cols.push_back(r);
         end
         col_cnt     = 0;
         row_sum_sg  = 0;
         row_sum_sgn = 0;
         rows_done++;
      endfunction

      function void check_result(col_result_type got);
         col_result_type exp_r;
         beats_out++;
         if (expected_cols.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: col %0d grad_in %h", got.column, got.grad_in);
            return;
         end
         exp_r = expected_cols.pop_front();
         if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch exp col %0d gi %h gs %h gb %h pv %b last %b",
                        exp_r.column, exp_r.grad_in, exp_r.grad_scale, exp_r.grad_shift,
                        exp_r.param_valid, exp_r.last);
               $display("         got col %0d gi %h gs %h gb %h pv %b last %b",
                        got.column, got.grad_in, got.grad_scale, got.grad_shift,
                        got.param_valid, got.last);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [lnb_pkg::LEN_W-1:0] csr_wdata;
   bit   rsp_no_stall;
   int   rsp_hold;
   int   cycles;

   lnb_req_if req ();
   lnb_rsp_if rsp ();

   lnb_scoreboard sb;

   layer_norm_backward_row_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #CLK_HALF clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom());
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_hold  <= 0;
         rsp.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp.ready <= 1'b0;
      end else if (!rsp_no_stall && $urandom_range(0, 3) == 0) begin
         rsp_hold  <= gap_len();
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         sb.check_result({rsp.column, rsp.grad_in, rsp.grad_scale, rsp.grad_shift,
                          rsp.param_valid, rsp.last});
   end

   bit req_no_gap;

   task automatic send_beat(logic [15:0] gy, logic [15:0] xv, logic [15:0] gam,
                            logic [15:0] mu, logic [15:0] rs, logic fin_row);
      int g;
      req.valid       <= 1'b1;
      req.grad_out    <= gy;
      req.x_value     <= xv;
      req.scale_value <= gam;
      req.row_mean    <= mu;
      req.row_rstd    <= rs;
      req.final_row   <= fin_row;
      do @(posedge clock); while (!req.ready);
      sb.note_input(gy, xv, gam, mu, rs, fin_row);
      g = req_no_gap ? 0 : gap_len();
      if (g > 0) begin
         req.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, int value);
      drain();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= lnb_pkg::LEN_W'(value);
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.write_reg(idx, value);
   endtask

   task automatic send_random_row(int len);
      logic [15:0] mu;
      logic [15:0] rs;
      logic [15:0] xv;
      logic [15:0] rsv;
      logic fin_row;
      logic fin_beat;
      mu      = pick16();
      rs      = ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom_range(64, 1024));
      fin_row = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 5) == 0) mu = pick16();
         xv = ($urandom_range(0, 2) == 0) ? pick16()
                                          : 16'(mu + $urandom_range(0, 8191) - 4096);
         rsv      = (i == len - 1 || $urandom_range(0, 1)) ? rs : pick16();
         fin_beat = (i == len - 1) ? fin_row : logic'($urandom_range(0, 1));
         send_beat(pick16(), xv, pick16(), mu, rsv, fin_beat);
      end
   endtask

   initial begin
      int len_plan[12];
      int plan_idx;
      int eff, rows;
      len_plan     = '{1, 2, 5, 64, 0, 127, 8, 3, 16, 31, 4, 42};
      sb           = new();
      reset        = 1;
      csr_we       = 0;
      csr_index    = lnb_pkg::CSR_ROW_LENGTH;
      csr_wdata    = '0;
      rsp_no_stall = 0;
      req_no_gap   = 0;
      req.valid    = 0;
      req.grad_out = '0;
      req.x_value  = '0;
      req.scale_value = '0;
      req.row_mean = '0;
      req.row_rstd = '0;
      req.final_row = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, non-final then final accumulation, both scale modes
      write_csr(lnb_pkg::CSR_ROW_LENGTH, 3);
      send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 0);
      send_beat(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 1);
      send_beat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 0);
      send_beat(16'h1000, 16'h0000, 16'h1000, 16'h0000, 16'h0100, 0);
      send_beat(16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 0);
      send_beat(16'hf000, 16'hf000, 16'hffff, 16'h0800, 16'h0000, 1);
      write_csr(lnb_pkg::CSR_USE_SCALE, 0);
      send_beat(16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'hffff, 1);
      send_beat(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 1);
      send_beat(16'h0001, 16'h0002, 16'h0003, 16'h0000, 16'h0180, 1);
      // partial row dropped by a row length write
      send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 0);
      send_beat(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'hffff, 0);
      write_csr(lnb_pkg::CSR_ROW_LENGTH, 1);
      write_csr(lnb_pkg::CSR_USE_SCALE, 1);
      send_beat(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'hffff, 1);
      send_beat(16'h4000, 16'hc000, 16'h8000, 16'h0000, 16'h00ff, 0);
      send_beat(16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 1);

      plan_idx = 0;
      while (sb.beats_in < ITEM_TARGET) begin
         write_csr(lnb_pkg::CSR_ROW_LENGTH, len_plan[plan_idx % 12]);
         if (plan_idx % 3 == 0 || $urandom_range(0, 1))
            write_csr(lnb_pkg::CSR_USE_SCALE, int'($urandom_range(0, 1)));
         eff = sb.eff_len();
         rows = (eff >= 32) ? 1 : 40 / eff + 1;
         rsp_no_stall = ($urandom_range(0, 3) == 0);
         req_no_gap   = ($urandom_range(0, 3) == 0);
         for (int r = 0; r < rows; r++) begin
            if ((plan_idx == 0 && r == 1) || $urandom_range(0, 7) == 0) drain();
            send_random_row(eff);
         end
         if ($urandom_range(0, 5) == 0 && eff > 1) begin
            for (int i = 0; i < eff - 1; i++)
               send_beat(pick16(), pick16(), pick16(), pick16(), pick16(), 1);
         end
         plan_idx++;
      end
      req.valid <= 1'b0;
      rsp_no_stall = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d input beats over %0d row settings, %0d rows completed",
               sb.beats_in, plan_idx, sb.rows_done);
      $display("checked %0d result beats, %0d mismatches", sb.beats_out, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/lnb_pkg.sv
hdl/lnb_req_if.sv
hdl/lnb_rsp_if.sv
hdl/lnb_ctrl.sv
hdl/lnb_datapath.sv
hdl/layer_norm_backward_row_unit.sv
verif/layer_norm_backward_row_unit_tb.sv
